/* design/mp2d_pkg.sv */
`timescale 1ns / 1ps
package mp2d_pkg;

  localparam int PLANE_REG_BITS = 11;
  localparam int WIN_REG_BITS   = 3;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PLANE_HEIGHT  = 3'd0,
    REG_PLANE_WIDTH   = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_STEP_ROWS     = 3'd4,
    REG_STEP_COLS     = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COL,
    ST_OUT
  } state_t;

  // per-cycle commands shared by every column cell
  typedef struct packed {
    logic shift;
    logic calc;
  } cell_ctl_t;

endpackage

/* design/max_pool_2d_with_argmax_unit.sv */
`timescale 1ns / 1ps
// Streaming 2-D max pooling with argmax. Signed pixels of one channel plane
// arrive in raster order on the s_ stream, planes back to back. Every pixel
// that closes a pooling window (window tops and lefts at multiples of the
// strides, windows wholly inside the plane) produces one transfer on the m_
// stream: window maximum, first position of that maximum in row-major order,
// pooled output coordinates, and tlast on the plane's final result. The
// comparison starts at -(2^(DATA_BITS-1)-1), so a window holding only smaller
// samples reports that value at position 0,0. Each pixel goes through
// a registered line-memory read, a shift through the chain of column cells,
// a per-column maximum, and the cross-column merge into the output register.
// A finished result waits in the output register while the next pixel is
// taken. Any valid configuration write restarts the plane at row 0, column 0.
// Geometry values of 0 act as 1; oversize values are clamped to the maxima.
module max_pool_2d_with_argmax_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 4,
  parameter int DATA_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pixel
  input  logic [((DATA_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // max_value, win_row, win_col, out_row, out_col
  output logic [((DATA_BITS+2*$clog2(MAX_WINDOW)+2*$clog2(MAX_WIDTH)+7)/8)*8-1:0] m_tdata,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic [mp2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mp2d_pkg::PLANE_REG_BITS-1:0] cfg_data
);
  import mp2d_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = CW + 1;
  localparam int KB    = $clog2(MAX_WINDOW + 1);
  localparam int WB    = $clog2(MAX_WINDOW);
  localparam int OUT_W = ((DATA_BITS + 2*WB + 2*CW + 7) / 8) * 8;
  localparam int MEM_W = (MAX_WINDOW - 1) * DATA_BITS;
  localparam logic signed [DATA_BITS-1:0] START = {1'b1, {(DATA_BITS-2){1'b0}}, 1'b1};

  // configuration registers
  logic [PLANE_REG_BITS-1:0] plane_height, plane_width;
  logic [WIN_REG_BITS-1:0]   window_height, window_width, step_rows, step_cols;
  logic                      cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PLANE_HEIGHT, REG_PLANE_WIDTH, REG_WINDOW_HEIGHT,
        REG_WINDOW_WIDTH, REG_STEP_ROWS, REG_STEP_COLS: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height  <= PLANE_REG_BITS'(8);
      plane_width   <= PLANE_REG_BITS'(8);
      window_height <= WIN_REG_BITS'(2);
      window_width  <= WIN_REG_BITS'(2);
      step_rows     <= WIN_REG_BITS'(2);
      step_cols     <= WIN_REG_BITS'(2);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PLANE_HEIGHT:  plane_height  <= cfg_data;
        REG_PLANE_WIDTH:   plane_width   <= cfg_data;
        REG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_REG_BITS-1:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_REG_BITS-1:0];
        REG_STEP_ROWS:     step_rows     <= cfg_data[WIN_REG_BITS-1:0];
        REG_STEP_COLS:     step_cols     <= cfg_data[WIN_REG_BITS-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // effective geometry after clamping
  logic [HW-1:0]           h_eff, w_eff;
  logic [KB-1:0]           kh, kw;
  logic [WIN_REG_BITS-1:0] sh, sw;

  always_comb begin
    if (plane_height == '0)                    h_eff = HW'(1);
    else if (32'(plane_height) > MAX_WIDTH)    h_eff = HW'(MAX_WIDTH);
    else                                       h_eff = HW'(plane_height);
    if (plane_width == '0)                     w_eff = HW'(1);
    else if (32'(plane_width) > MAX_WIDTH)     w_eff = HW'(MAX_WIDTH);
    else                                       w_eff = HW'(plane_width);
    if (window_height == '0)                   kh = KB'(1);
    else if (32'(window_height) > MAX_WINDOW)  kh = KB'(MAX_WINDOW);
    else                                       kh = KB'(window_height);
    if (window_width == '0)                    kw = KB'(1);
    else if (32'(window_width) > MAX_WINDOW)   kw = KB'(MAX_WINDOW);
    else                                       kw = KB'(window_width);
    sh = (step_rows == '0) ? WIN_REG_BITS'(1) : step_rows;
    sw = (step_cols == '0) ? WIN_REG_BITS'(1) : step_cols;
  end

  // position counters; rph/cph track the window top/left modulo the stride
  // and orow/ocol the quotient, so no divider is needed
  state_t state, state_next;
  logic   acc;
  logic [CW-1:0]           row_cnt, col_cnt, orow, ocol;
  logic [CW-1:0]           row_next, col_next, orow_next, ocol_next;
  logic [WIN_REG_BITS-1:0] rph, cph, rph_next, cph_next;
  logic [HW-1:0]           r1, c1;
  logic                    col_wrap, win_hit, last_hit;

  assign acc = s_tvalid && s_tready;
  assign r1  = {1'b0, row_cnt} + HW'(1);
  assign c1  = {1'b0, col_cnt} + HW'(1);

  always_comb begin
    win_hit  = (32'(r1) >= 32'(kh)) && (32'(c1) >= 32'(kw)) && (rph == '0) && (cph == '0);
    last_hit = (32'(row_cnt) + 32'(sh) >= 32'(h_eff)) &&
               (32'(col_cnt) + 32'(sw) >= 32'(w_eff));
    col_wrap = (c1 >= w_eff);
    col_next = col_wrap ? '0 : c1[CW-1:0];
    row_next = row_cnt;
    if (col_wrap) begin
      row_next = (r1 >= h_eff) ? '0 : r1[CW-1:0];
    end

    cph_next  = cph;
    ocol_next = ocol;
    if (32'(col_next) + 1 == 32'(kw)) begin
      cph_next  = '0;
      ocol_next = '0;
    end else if (32'(col_next) + 1 > 32'(kw)) begin
      if ({1'b0, cph} + 4'd1 >= {1'b0, sw}) begin
        cph_next  = '0;
        ocol_next = ocol + CW'(1);
      end else begin
        cph_next  = cph + WIN_REG_BITS'(1);
      end
    end

    rph_next  = rph;
    orow_next = orow;
    if (col_wrap) begin
      if (32'(row_next) + 1 == 32'(kh)) begin
        rph_next  = '0;
        orow_next = '0;
      end else if (32'(row_next) + 1 > 32'(kh)) begin
        if ({1'b0, rph} + 4'd1 >= {1'b0, sh}) begin
          rph_next  = '0;
          orow_next = orow + CW'(1);
        end else begin
          rph_next  = rph + WIN_REG_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_cnt <= '0;
      col_cnt <= '0;
      rph     <= '0;
      cph     <= '0;
      orow    <= '0;
      ocol    <= '0;
    end else if (acc) begin
      row_cnt <= row_next;
      col_cnt <= col_next;
      rph     <= rph_next;
      cph     <= cph_next;
      orow    <= orow_next;
      ocol    <= ocol_next;
    end
  end

  // per-item payload held while it walks through the cells
  logic [DATA_BITS-1:0] pix_q;
  logic [CW-1:0]        addr_q, orow_q, ocol_q;
  logic                 emit_q, last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
    end else if (acc) begin
      emit_q <= win_hit;
    end
    if (acc) begin
      pix_q  <= s_tdata[DATA_BITS-1:0];
      addr_q <= col_cnt;
      orow_q <= orow;
      ocol_q <= ocol;
      last_q <= last_hit;
    end
  end

  // line memory: one word per column holds the previous rows, newest lowest
  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] rd_q;
  logic             mem_we;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q <= line_mem[col_cnt];
    end
    if (mem_we) begin
      line_mem[addr_q] <= MEM_W'({rd_q, pix_q});
    end
  end

  // chain of column cells: cell 0 takes the newest column, each cell hands
  // its column to the next one on every shift
  cell_ctl_t ctl;
  logic [MAX_WINDOW*DATA_BITS-1:0] cin  [MAX_WINDOW];
  logic [MAX_WINDOW*DATA_BITS-1:0] cout [MAX_WINDOW];
  logic signed [DATA_BITS-1:0]     cbest [MAX_WINDOW];
  logic [WB-1:0]                   crow  [MAX_WINDOW];

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cin[j] = {rd_q, pix_q};
    end else begin : g_link
      assign cin[j] = cout[j-1];
    end
    mp2d_cell #(
      .DATA_BITS  (DATA_BITS),
      .MAX_WINDOW (MAX_WINDOW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .kh       (kh),
      .col_in   (cin[j]),
      .col_out  (cout[j]),
      .best_val (cbest[j]),
      .best_row (crow[j])
    );
  end

  // merge column results left to right: larger value wins, on a tie the
  // smaller row wins, and a later column never beats an equal earlier one
  logic signed [DATA_BITS-1:0] m_best;
  logic [WB-1:0]               m_row, m_col;

  always_comb begin
    logic [KB-1:0]               idx;
    logic signed [DATA_BITS-1:0] cv;
    logic [WB-1:0]               cr;
    m_best = START;
    m_row  = '0;
    m_col  = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      idx = kw - KB'(j) - KB'(1);
      cv  = cbest[idx[WB-1:0]];
      cr  = crow[idx[WB-1:0]];
      if ((32'(j) < 32'(kw)) && ((cv > m_best) || ((cv == m_best) && (cr < m_row)))) begin
        m_best = cv;
        m_row  = cr;
        m_col  = WB'(j);
      end
    end
  end

  // sequencer
  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_COL;
      ST_COL:  state_next = ST_OUT;
      ST_OUT:  if (!emit_q || !m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    mem_we    = (state == ST_LOAD);
    ctl.shift = (state == ST_LOAD);
    ctl.calc  = (state == ST_COL);
    out_load  = (state == ST_OUT) && emit_q && (!m_tvalid || m_tready);
  end

  // output register: hold until the downstream side takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= OUT_W'({ocol_q, orow_q, m_col, m_row, m_best});
      m_tlast <= last_q;
    end
  end

endmodule

/* design/mp2d_cell.sv */
`timescale 1ns / 1ps
module mp2d_cell #(
  parameter int DATA_BITS  = 32,
  parameter int MAX_WINDOW = 4
) (
  input  logic                                clk,
  input  mp2d_pkg::cell_ctl_t                 ctl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     kh,
  input  logic [MAX_WINDOW*DATA_BITS-1:0]     col_in,
  output logic [MAX_WINDOW*DATA_BITS-1:0]     col_out,
  output logic signed [DATA_BITS-1:0]         best_val,
  output logic [$clog2(MAX_WINDOW)-1:0]       best_row
);
  import mp2d_pkg::*;

  localparam int KB = $clog2(MAX_WINDOW + 1);
  localparam int WB = $clog2(MAX_WINDOW);
  localparam logic signed [DATA_BITS-1:0] START = {1'b1, {(DATA_BITS-2){1'b0}}, 1'b1};

  // entry 0 holds the newest row, higher entries hold older rows
  logic [MAX_WINDOW*DATA_BITS-1:0] col;
  logic signed [DATA_BITS-1:0]     best_c;
  logic [WB-1:0]                   row_c;

  assign col_out = col;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col <= col_in;
    end
    if (ctl.calc) begin
      best_val <= best_c;
      best_row <= row_c;
    end
  end

  // walk window rows top to bottom; strict compare keeps the first maximum
  always_comb begin
    logic signed [DATA_BITS-1:0] v;
    logic [KB-1:0]               idx;
    best_c = START;
    row_c  = '0;
    for (int k = MAX_WINDOW - 1; k >= 0; k--) begin
      v   = signed'(col[k*DATA_BITS +: DATA_BITS]);
      idx = kh - KB'(k) - KB'(1);
      if ((KB'(k) < kh) && (v > best_c)) begin
        best_c = v;
        row_c  = idx[WB-1:0];
      end
    end
  end

endmodule

/* design/mp2d_checker.sv */
`timescale 1ns / 1ps
module mp2d_checker #(
  parameter int OUT_W = 56
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);
  import mp2d_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // one pixel in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // a fresh result comes from a pixel accepted before the load, column and output states
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
    else $error("result without matching pixel");

  // no pixel is taken during the cycles a result is being formed
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##1 !s_tready ##1 !s_tready)
    else $error("input taken mid-item");

endmodule

bind max_pool_2d_with_argmax_unit mp2d_checker #(.OUT_W(OUT_W)) u_mp2d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* verif/max_pool_2d_with_argmax_unit_tb.sv */
`timescale 1ns / 1ps
module max_pool_2d_with_argmax_unit_tb;
  import mp2d_pkg::*;

  localparam int LINE_W   = 1024;
  localparam int WIN_MAX  = 4;
  localparam int N_RANDOM = 1250;
  localparam int SETTLE   = 12;   // four-stage pixel pipeline plus margin

  // Result as it leaves the block: {tlast, tdata}, max_value in the lowest bits.
  typedef struct packed {
    logic       plane_last;
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic [1:0] win_col;
    logic [1:0] win_row;
    logic [31:0] max_value;
  } pool_result_t;

  // One row of the directed table: a register write or a pixel, with an
  // optional typed-in result that replaces the predicted one.
  typedef struct {
    bit           is_cfg;
    logic [2:0]   idx;
    logic [10:0]  data;
    logic [31:0]  pix;
    bit           has_exp;
    pool_result_t res;
  } stim_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // pixel
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;        // max_value, win_row, win_col, out_row, out_col
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [PLANE_REG_BITS-1:0] cfg_data = '0;

  max_pool_2d_with_argmax_unit uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the geometry registers, the line store and the
  // raster position.
  // ---------------------------------------------------------------------------
  logic [10:0] plane_h_reg, plane_w_reg;
  logic [2:0]  win_h_reg, win_w_reg, stride_r_reg, stride_c_reg;
  logic signed [31:0] line_mem [WIN_MAX][LINE_W];
  int unsigned row_pos, col_pos;

  pool_result_t pooled_results_q[$];
  int errors = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [10:0] val);
    case (idx)
      REG_PLANE_HEIGHT:  plane_h_reg  = val;
      REG_PLANE_WIDTH:   plane_w_reg  = val;
      REG_WINDOW_HEIGHT: win_h_reg    = val[2:0];
      REG_WINDOW_WIDTH:  win_w_reg    = val[2:0];
      REG_STEP_ROWS:     stride_r_reg = val[2:0];
      REG_STEP_COLS:     stride_c_reg = val[2:0];
      default: return;   // unknown index: no effect at all, position kept
    endcase
    row_pos = 0;
    col_pos = 0;
  endfunction

  // Store one pixel, and when it closes an aligned window produce its result.
  function automatic bit pool_window_step(logic signed [31:0] pix,
                                          output pool_result_t res);
    int unsigned ph, pw, kh, kw, sr, sc, top, left, br, bc;
    logic signed [31:0] best, v;
    bit hit;
    ph = clamp_dim(plane_h_reg, LINE_W);
    pw = clamp_dim(plane_w_reg, LINE_W);
    kh = clamp_dim(win_h_reg, WIN_MAX);
    kw = clamp_dim(win_w_reg, WIN_MAX);
    sr = (stride_r_reg == 0) ? 1 : stride_r_reg;
    sc = (stride_c_reg == 0) ? 1 : stride_c_reg;
    hit = 0;
    res = '0;
    line_mem[row_pos % WIN_MAX][col_pos] = pix;
    if (row_pos + 1 >= kh && col_pos + 1 >= kw) begin
      top  = row_pos + 1 - kh;
      left = col_pos + 1 - kw;
      if (top % sr == 0 && left % sc == 0) begin
        best = -32'sd2147483647;
        br = 0;
        bc = 0;
        for (int i = 0; i < kh; i++) begin
          for (int j = 0; j < kw; j++) begin
            v = line_mem[(top + i) % WIN_MAX][left + j];
            if (v > best) begin
              best = v;
              br = i;
              bc = j;
            end
          end
        end
        res.max_value  = best;
        res.win_row    = br[1:0];
        res.win_col    = bc[1:0];
        res.out_row    = 10'(top / sr);
        res.out_col    = 10'(left / sc);
        res.plane_last = (row_pos + sr >= ph) && (col_pos + sc >= pw);
        hit = 1;
      end
    end
    col_pos++;
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ph) row_pos = 0;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every output transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pool_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata};
      if (pooled_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
      end else begin
        want = pooled_results_q.pop_front();
        check_field("max_value",  got.max_value,  want.max_value);
        check_field("win_row",    got.win_row,    want.win_row);
        check_field("win_col",    got.win_col,    want.win_col);
        check_field("out_row",    got.out_row,    want.out_row);
        check_field("out_col",    got.out_col,    want.out_col);
        check_field("plane_last", got.plane_last, want.plane_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch stall patterns now and then; hold off once for a long
  // stretch so the block fills and backs up its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned cyc, hold, mode;
    bit held_once;
    cyc = 0;
    hold = 0;
    mode = 0;
    held_once = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (!held_once && cyc > 2000) begin
        held_once = 1;
        hold = 400;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= (cyc % 5) < 3;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Offer one pixel, in bursts with random gaps; predict on the transfer.
  task automatic send_pixel(logic [31:0] pix, bit typed, pool_result_t typed_res);
    pool_result_t res;
    bit hit;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    hit = pool_window_step(pix, res);
    if (typed) pooled_results_q.push_back(typed_res);
    else if (hit) pooled_results_q.push_back(res);
  endtask

  // Stop offering and let every pending result drain before a register write.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pooled_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drop the write enable for one cycle so back-to-back writes never land
  // two assignments on it in the same step.
  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [10:0] pick_plane_dim();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd2047;
      default: return 11'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0001;
      3, 4, 5: return 32'($urandom_range(0, 3));   // small range forces ties
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab[$];

  initial begin
    pool_result_t none;
    int unsigned sent, plane_px, n_px;
    none = '0;

    plane_h_reg  = 11'd8;
    plane_w_reg  = 11'd8;
    win_h_reg    = 3'd2;
    win_w_reg    = 3'd2;
    stride_r_reg = 3'd2;
    stride_c_reg = 3'd2;
    row_pos = 0;
    col_pos = 0;

    // 2x2 plane, 2x2 window: one result per plane
    dir_tab.push_back('{1, REG_PLANE_HEIGHT, 11'd2, 0, 0, none});
    dir_tab.push_back('{1, REG_PLANE_WIDTH,  11'd2, 0, 0, none});
    // all samples at the most negative value never beat the starting maximum
    repeat (3) dir_tab.push_back('{0, 0, 0, 32'h8000_0000, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'h8000_0000, 1,
        '{plane_last: 1, out_col: 0, out_row: 0, win_col: 0, win_row: 0,
          max_value: 32'h8000_0001}});
    // tie: first maximum in row-major order wins
    dir_tab.push_back('{0, 0, 0, 32'd1, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd5, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd5, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd2, 1,
        '{plane_last: 1, out_col: 0, out_row: 0, win_col: 1, win_row: 0,
          max_value: 32'd5}});
    // largest positive in the bottom-right corner
    dir_tab.push_back('{0, 0, 0, 32'hffff_ffff, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'h8000_0000, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd7, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'h7fff_ffff, 1,
        '{plane_last: 1, out_col: 0, out_row: 0, win_col: 1, win_row: 1,
          max_value: 32'h7fff_ffff}});
    // zero plane, zero window, zero stride: every pixel is its own window
    dir_tab.push_back('{1, REG_PLANE_HEIGHT,  11'd0, 0, 0, none});
    dir_tab.push_back('{1, REG_PLANE_WIDTH,   11'd0, 0, 0, none});
    dir_tab.push_back('{1, REG_WINDOW_HEIGHT, 11'd0, 0, 0, none});
    dir_tab.push_back('{1, REG_WINDOW_WIDTH,  11'd0, 0, 0, none});
    dir_tab.push_back('{1, REG_STEP_ROWS,     11'd0, 0, 0, none});
    dir_tab.push_back('{1, REG_STEP_COLS,     11'd0, 0, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'h7fff_ffff, 1,
        '{plane_last: 1, out_col: 0, out_row: 0, win_col: 0, win_row: 0,
          max_value: 32'h7fff_ffff}});
    dir_tab.push_back('{0, 0, 0, 32'h8000_0000, 1,
        '{plane_last: 1, out_col: 0, out_row: 0, win_col: 0, win_row: 0,
          max_value: 32'h8000_0001}});
    // oversize window on a 1x1 plane: nothing fits, no result
    dir_tab.push_back('{1, REG_WINDOW_HEIGHT, 11'd7, 0, 0, none});
    dir_tab.push_back('{1, REG_WINDOW_WIDTH,  11'd5, 0, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd3, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd4, 0, none});
    // 1x3 plane, 1x1 window, stride 1; unknown indexes mid-row keep the position
    dir_tab.push_back('{1, REG_PLANE_WIDTH,   11'd3, 0, 0, none});
    dir_tab.push_back('{1, REG_WINDOW_HEIGHT, 11'd1, 0, 0, none});
    dir_tab.push_back('{1, REG_WINDOW_WIDTH,  11'd1, 0, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd11, 1,
        '{plane_last: 0, out_col: 0, out_row: 0, win_col: 0, win_row: 0,
          max_value: 32'd11}});
    dir_tab.push_back('{1, 3'd6, 11'h7ff, 0, 0, none});
    dir_tab.push_back('{1, 3'd7, 11'h001, 0, 0, none});
    dir_tab.push_back('{0, 0, 0, 32'd12, 1,
        '{plane_last: 0, out_col: 1, out_row: 0, win_col: 0, win_row: 0,
          max_value: 32'd12}});
    dir_tab.push_back('{0, 0, 0, 32'd13, 1,
        '{plane_last: 1, out_col: 2, out_row: 0, win_col: 0, win_row: 0,
          max_value: 32'd13}});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        drain_block();
        write_reg(dir_tab[k].idx, dir_tab[k].data);
      end else begin
        send_pixel(dir_tab[k].pix, dir_tab[k].has_exp, dir_tab[k].res);
      end
    end

    // Random phases: new geometry each phase, mostly whole small planes.
    sent = 0;
    while (sent < N_RANDOM) begin
      drain_block();
      write_reg(REG_PLANE_HEIGHT,  pick_plane_dim());
      write_reg(REG_PLANE_WIDTH,   pick_plane_dim());
      write_reg(REG_WINDOW_HEIGHT, 11'($urandom_range(0, 7)));
      write_reg(REG_WINDOW_WIDTH,  11'($urandom_range(0, 7)));
      write_reg(REG_STEP_ROWS,     11'($urandom_range(0, 7)));
      write_reg(REG_STEP_COLS,     11'($urandom_range(0, 7)));
      if ($urandom_range(0, 4) == 0) write_reg(3'($urandom_range(6, 7)), 11'($urandom));
      plane_px = clamp_dim(plane_h_reg, LINE_W) * clamp_dim(plane_w_reg, LINE_W);
      n_px = plane_px * $urandom_range(1, 3) + $urandom_range(0, 3);
      if (n_px > 150) n_px = $urandom_range(40, 150);
      repeat (n_px) begin
        send_pixel(pick_pixel(), 0, none);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (pooled_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
